[sv/ssc_pkg.sv]
// Shared types, constants and helpers for the shadow stack checker.
// No dependencies; every other file imports this package.
`default_nettype none

package ssc_pkg;

    // Stack geometry
    localparam int DEPTH = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    // Field widths
    localparam int DATA_W = 64;
    localparam int CORE_W = 4;
    localparam int KIND_W = 2;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_CORE_ID = 1'b0;
    localparam logic [CORE_W-1:0] CORE_ID_RESET = 4'd1;

    // Command and packet type codes
    localparam logic CMD_TRACE     = 1'b0;
    localparam logic CMD_EPOCH_END = 1'b1;
    localparam logic [1:0] TYPE_CALL = 2'd1;
    localparam logic [1:0] TYPE_RET  = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_MISMATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FORWARD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SPILL    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END      = 2'd3;

    localparam logic [DATA_W-1:0] END_MARKER = 64'h0000_0000_FFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FWD,
        S_END,
        S_POP,
        S_SPILL,
        S_FLUSH
    } state_t;

    // Request from the control unit to the stack memory
    typedef struct packed {
        logic              we;
        logic [AW-1:0]     waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [AW-1:0]     raddr;
    } mem_req_t;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : AW'(idx + 1'b1);
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] idx);
        return (idx == '0) ? AW'(DEPTH - 1) : AW'(idx - 1'b1);
    endfunction

    // (from - n) mod DEPTH, with from < DEPTH and n <= DEPTH
    function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] from,
                                                input logic [CW-1:0] n);
        logic [AW:0] t;
        t = {1'b0, from} + (AW+1)'(DEPTH) - (AW+1)'(n);
        return (t >= (AW+1)'(DEPTH)) ? AW'(t - (AW+1)'(DEPTH)) : AW'(t);
    endfunction

endpackage

`default_nettype wire

[sv/ssc_if.sv]
// Valid/ready channel interfaces for trace beats and result beats.
// Depends on ssc_pkg for field widths.
`default_nettype none

interface ssc_in_if;
    import ssc_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [DATA_W-1:0] payload;

    modport source (output valid, cmd, payload, input ready);
    modport sink   (input valid, cmd, payload, output ready);
endinterface

interface ssc_out_if;
    import ssc_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] expected;
    logic [CORE_W-1:0] source_core;
    logic              last;

    modport source (output valid, kind, data, expected, source_core, last, input ready);
    modport sink   (input valid, kind, data, expected, source_core, last, output ready);
endinterface

`default_nettype wire

[sv/ssc_stack_mem.sv]
// Shadow stack storage: one write port, one read port, registered read data.
// Depends on ssc_pkg for depth, widths and the request struct.
`default_nettype none

module ssc_stack_mem (
    input  wire logic                      clk,
    input  wire ssc_pkg::mem_req_t         req,
    output logic [ssc_pkg::DATA_W-1:0]     rd_data
);
    import ssc_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[sv/ssc_ctrl.sv]
// Control unit: decodes trace beats, sequences stack read-modify-write,
// flush walk and the result output register. Depends on ssc_pkg, ssc_if.
`default_nettype none

module ssc_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [ssc_pkg::CORE_W-1:0] core_id,
    ssc_in_if.sink                         in_ch,
    ssc_out_if.source                      out_ch,
    output ssc_pkg::mem_req_t              mem_req,
    input  wire logic [ssc_pkg::DATA_W-1:0] rd_data
);
    import ssc_pkg::*;

    state_t            state_reg, state_next;
    logic [AW-1:0]     top_reg, top_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [AW-1:0]     rp_reg, rp_next;
    logic [DATA_W-1:0] pkt_reg, pkt_next;

    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] out_exp_reg;
    logic [CORE_W-1:0] out_src_reg;
    logic              out_last_reg;

    logic              in_ready;
    logic              accept;
    logic              out_free;
    logic              is_end, is_call, is_ret;
    logic              full, empty;
    logic [DATA_W-1:0] pop_exp;
    logic              pop_match;
    logic [AW-1:0]     oldest;

    logic              emit;
    logic [KIND_W-1:0] e_kind;
    logic [DATA_W-1:0] e_data;
    logic [DATA_W-1:0] e_exp;
    logic              e_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_ch.valid && in_ready;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign is_end    = (in_ch.cmd == CMD_EPOCH_END);
    assign is_call   = !is_end && (in_ch.payload[1:0] == TYPE_CALL);
    assign is_ret    = !is_end && (in_ch.payload[1:0] == TYPE_RET);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_exp   = rd_data + 64'd1;
    assign pop_match = (pop_exp == pkt_reg);
    assign oldest    = slot_back(top_reg, count_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_end)
                    begin
                        state_next = empty ? S_END : S_FLUSH;
                    end
                    else if (is_call)
                    begin
                        state_next = full ? S_SPILL : S_IDLE;
                    end
                    else if (is_ret)
                    begin
                        state_next = empty ? S_FWD : S_POP;
                    end
                end
            end
            S_FWD, S_END, S_SPILL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                if (pop_match || out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (out_free && rem_reg == CW'(1))
                begin
                    state_next = S_END;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        emit       = 1'b0;
        e_kind     = KIND_SPILL;
        e_data     = rd_data;
        e_exp      = '0;
        e_last     = 1'b0;
        mem_req    = '0;
        top_next   = top_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        rp_next    = rp_reg;
        pkt_next   = accept ? in_ch.payload : pkt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_end)
                    begin
                        if (!empty)
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = oldest;
                            rem_next      = count_reg;
                            rp_next       = slot_inc(oldest);
                        end
                    end
                    else if (is_call)
                    begin
                        if (full)
                        begin
                            // oldest entry sits at top when full
                            mem_req.re    = 1'b1;
                            mem_req.raddr = top_reg;
                        end
                        else
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = top_reg;
                            mem_req.wdata = in_ch.payload;
                            top_next      = slot_inc(top_reg);
                            count_next    = CW'(count_reg + 1'b1);
                        end
                    end
                    else if (is_ret)
                    begin
                        if (!empty)
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = slot_dec(top_reg);
                            top_next      = slot_dec(top_reg);
                            count_next    = CW'(count_reg - 1'b1);
                        end
                    end
                end
            end
            S_FWD:
            begin
                if (out_free)
                begin
                    emit   = 1'b1;
                    e_kind = KIND_FORWARD;
                    e_data = pkt_reg;
                    e_last = 1'b1;
                end
            end
            S_END:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_END;
                    e_data     = END_MARKER;
                    e_last     = 1'b1;
                    count_next = '0;
                end
            end
            S_POP:
            begin
                if (!pop_match && out_free)
                begin
                    emit   = 1'b1;
                    e_kind = KIND_MISMATCH;
                    e_data = pkt_reg;
                    e_exp  = pop_exp;
                    e_last = 1'b1;
                end
            end
            S_SPILL:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    e_kind        = KIND_SPILL;
                    e_data        = rd_data;
                    e_last        = 1'b1;
                    mem_req.we    = 1'b1;
                    mem_req.waddr = top_reg;
                    mem_req.wdata = pkt_reg;
                    top_next      = slot_inc(top_reg);
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    e_kind   = KIND_SPILL;
                    e_data   = rd_data;
                    rem_next = CW'(rem_reg - 1'b1);
                    if (rem_reg != CW'(1))
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = rp_reg;
                        rp_next       = slot_inc(rp_reg);
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            rp_reg    <= rp_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg <= pkt_next;
        if (emit)
        begin
            out_kind_reg <= e_kind;
            out_data_reg <= e_data;
            out_exp_reg  <= e_exp;
            out_src_reg  <= core_id;
            out_last_reg <= e_last;
        end
    end

    assign in_ch.ready        = in_ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.kind        = out_kind_reg;
    assign out_ch.data        = out_data_reg;
    assign out_ch.expected    = out_exp_reg;
    assign out_ch.source_core = out_src_reg;
    assign out_ch.last        = out_last_reg;

endmodule

`default_nettype wire

[sv/shadow_stack_checker_unit.sv]
// A call into a non-full stack is written while the unit stays idle; a return into a held
// stack or a call into a full stack reads the stack memory, then compares or emits; a
// forwarded return emits without a read. On epoch end the flush walk emits one beat per
// held call, then the marker. Throughput is set by the registered read of the stack memory
// and the one-result output register; backpressure on results stalls the walk beat by beat.
// Reset (rst_n, async low) empties the stack and sets core_id to 1; no clearing pass.
`default_nettype none

module shadow_stack_checker_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    ssc_in_if.sink                           trace_in,
    ssc_out_if.source                        result_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ssc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ssc_pkg::PDATA_W-1:0] pwdata,
    output logic [ssc_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);
    import ssc_pkg::*;

    logic [CORE_W-1:0] core_id_reg;
    logic              cfg_wr;
    mem_req_t          mem_req;
    logic [DATA_W-1:0] rd_data;

    // Configuration: single register, core_id, at byte address 0.
    // Writes to other word addresses are dropped; reads there return zero.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CORE_ID);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_id_reg <= CORE_ID_RESET;
        end
        else if (cfg_wr)
        begin
            core_id_reg <= pwdata[CORE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CORE_ID) ? PDATA_W'(core_id_reg) : '0;

    // Control: decode beats, drive stack read/modify/write, hold one result beat
    ssc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .core_id (core_id_reg),
        .in_ch   (trace_in),
        .out_ch  (result_out),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // Shadow stack ring storage
    ssc_stack_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

[bench/shadow_stack_checker_unit_tb.sv]
// Self-checking bench for shadow_stack_checker_unit: trace beats in, result beats out,
// core_id through the APB port. Depends on ssc_pkg and the channel interfaces in ssc_if.
`default_nettype none

module shadow_stack_checker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssc_pkg::*;

    // Byte address of core_id; the next word has no register behind it.
    localparam logic [PADDR_W-1:0] CORE_ID_ADDR  = PADDR_W'(4 * REG_CORE_ID);
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(4);
    // Watchdog: cycles in a row with no beat or register access on any port.
    localparam int STALL_LIMIT = 2000;
    // Long receiver hold-off, and the trace beat count that starts it.
    localparam int HOLD_CYCLES   = 150;
    localparam int HOLD_AT_BEAT  = 80;
    // Window of trace beats in which neither side idles.
    localparam int STEADY_FROM   = 170;
    localparam int STEADY_TO     = 230;
    // Settle time before a register write: longest flush walk plus margin.
    localparam int SETTLE_CYCLES = DEPTH + 10;
    localparam int ITEMS_PER_SET = 70;

    typedef struct {
        logic              cmd;
        logic [DATA_W-1:0] payload;
    } trace_item_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] expected;
        logic [CORE_W-1:0] core;
        logic              last;
    } check_result_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    ssc_in_if  trace_in();
    ssc_out_if result_out();

    shadow_stack_checker_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .trace_in   (trace_in),
        .result_out (result_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Predicted copy of the checker: held calls as a ring, write slot, count, tag.
    logic [DATA_W-1:0]   stack_mem [DEPTH];
    int                  stack_top;
    int                  stack_cnt;
    logic [CORE_W-1:0]   core_tag;

    trace_item_t         trace_backlog[$];   // beats waiting to be offered
    check_result_t       pending_results[$]; // predicted result beats, oldest first
    logic [DATA_W-1:0]   call_shadow[$];     // generator's view of held calls

    int  errors;
    int  trace_beats;
    int  result_beats;
    int  queued_useful;
    int  settings_run;
    int  idle_run;
    bit  trace_taken;
    bit  hold_results;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic note_mismatch(input string msg);
        errors++;
        $display("ERROR: %s", msg);
    endtask

    // Roll for an idle cycle on either side; no idling inside the steady window.
    function automatic bit take_break();
        if (trace_beats >= STEADY_FROM && trace_beats < STEADY_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 8;
    endfunction

    function automatic void expect_result(input logic [KIND_W-1:0] kind,
                                          input logic [DATA_W-1:0] data,
                                          input logic [DATA_W-1:0] ret_addr);
        check_result_t r;
        r.kind     = kind;
        r.data     = data;
        r.expected = ret_addr;
        r.core     = core_tag;
        r.last     = 1'b0;
        pending_results.push_back(r);
    endfunction

    // Apply one accepted trace beat to the predicted stack and queue its results.
    function automatic void predict_checker_results(input logic cmd,
                                                    input logic [DATA_W-1:0] pkt);
        int                first;
        int                slot;
        logic [DATA_W-1:0] ret_addr;
        first = pending_results.size();
        if (cmd == CMD_EPOCH_END) begin
            // Spill held calls oldest first, then the end marker
            for (int i = 0; i < stack_cnt; i++)
            begin
                slot = (stack_top + DEPTH - (stack_cnt - i)) % DEPTH;
                expect_result(KIND_SPILL, stack_mem[slot], '0);
            end
            expect_result(KIND_END, END_MARKER, '0);
            stack_cnt = 0;
        end
        else if (pkt[1:0] == TYPE_CALL) begin
            // A full ring overwrites its oldest entry, which sits at the write slot
            if (stack_cnt >= DEPTH)
                expect_result(KIND_SPILL, stack_mem[stack_top], '0);
            else
                stack_cnt++;
            stack_mem[stack_top] = pkt;
            stack_top = (stack_top + 1) % DEPTH;
        end
        else if (pkt[1:0] == TYPE_RET) begin
            if (stack_cnt != 0) begin
                // Pop even on a mismatch
                stack_top = (stack_top + DEPTH - 1) % DEPTH;
                ret_addr  = stack_mem[stack_top] + 64'd1;
                stack_cnt--;
                if (ret_addr != pkt)
                    expect_result(KIND_MISMATCH, pkt, ret_addr);
            end
            else begin
                expect_result(KIND_FORWARD, pkt, '0);
            end
        end
        if (pending_results.size() > first)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus generation: fills the backlog ahead of the driver
    // ---------------------------------------------------------------
    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_trace(input logic cmd, input logic [DATA_W-1:0] pkt);
        trace_item_t t;
        t.cmd     = cmd;
        t.payload = pkt;
        trace_backlog.push_back(t);
        // Ignored packet types do not count toward the item budget
        if (cmd == CMD_EPOCH_END || pkt[1:0] == TYPE_CALL || pkt[1:0] == TYPE_RET)
            queued_useful++;
    endfunction

    function automatic void gen_call();
        logic [DATA_W-1:0] p;
        p = rand_word();
        p[1:0] = TYPE_CALL;
        call_shadow.push_back(p);
        if (call_shadow.size() > DEPTH)
            call_shadow.delete(0);
        queue_trace(CMD_TRACE, p);
    endfunction

    // Return to the innermost call; a broken one carries a random address.
    function automatic void gen_return(input bit matching);
        logic [DATA_W-1:0] p;
        p = rand_word();
        p[1:0] = TYPE_RET;
        if (call_shadow.size() != 0) begin
            if (matching)
                p = call_shadow[call_shadow.size() - 1] + 64'd1;
            call_shadow.delete(call_shadow.size() - 1);
        end
        queue_trace(CMD_TRACE, p);
    endfunction

    function automatic void gen_epoch();
        queue_trace(CMD_EPOCH_END, rand_word());
        call_shadow.delete();
    endfunction

    // Mostly well-formed nests with random addresses; the rest is epoch ends
    // mid-nest, stray returns with random addresses, overflowing nests and ignored noise.
    function automatic void random_traffic(input int n_items);
        int target;
        int pick;
        int steps;
        logic [DATA_W-1:0] p;
        target = queued_useful + n_items;
        while (queued_useful < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                steps = $urandom_range(2, 12);
                repeat (steps)
                begin
                    if (call_shadow.size() == 0 || $urandom_range(0, 99) < 55)
                        gen_call();
                    else
                        gen_return($urandom_range(0, 99) < 85);
                end
            end
            else if (pick < 63) begin
                steps = $urandom_range(20, DEPTH + 6);
                repeat (steps) gen_call();
                repeat ($urandom_range(steps / 2, steps + 2)) gen_return($urandom_range(0, 9) != 0);
            end
            else if (pick < 76) begin
                gen_epoch();
            end
            else if (pick < 86) begin
                call_shadow.delete();
                repeat ($urandom_range(1, 3)) gen_return(1'b0);
            end
            else begin
                p = rand_word();
                p[1:0] = $urandom_range(0, 1) ? 2'b00 : 2'b11;
                queue_trace(CMD_TRACE, p);
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Trace driver: change at the falling edge, hold until the beat is taken
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && trace_in.valid && trace_in.ready) begin
            predict_checker_results(trace_in.cmd, trace_in.payload);
            trace_taken = 1'b1;
            trace_beats++;
        end
    end

    always @(negedge clk)
    begin : drive_trace
        trace_item_t nxt;
        logic        offer;
        if (rst_n && (trace_taken || !trace_in.valid)) begin
            trace_taken = 1'b0;
            offer = 1'b0;
            if (trace_backlog.size() != 0 && !take_break()) begin
                nxt   = trace_backlog[0];
                trace_backlog.delete(0);
                offer = 1'b1;
            end
            trace_in.valid <= offer;
            if (offer) begin
                trace_in.cmd     <= nxt.cmd;
                trace_in.payload <= nxt.payload;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: ready changes at the falling edge, beats checked at the rising edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
            result_out.ready <= !hold_results && !take_break();
    end

    always @(posedge clk)
    begin : check_results
        check_result_t want;
        if (rst_n && result_out.valid && result_out.ready) begin
            result_beats++;
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                        result_beats));
            end
            else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (result_out.kind !== want.kind)
                    note_mismatch($sformatf("beat %0d kind %0d, want %0d",
                                            result_beats, result_out.kind, want.kind));
                if (result_out.data !== want.data)
                    note_mismatch($sformatf("beat %0d data %h, want %h",
                                            result_beats, result_out.data, want.data));
                if (result_out.expected !== want.expected)
                    note_mismatch($sformatf("beat %0d expected %h, want %h",
                                            result_beats, result_out.expected, want.expected));
                if (result_out.source_core !== want.core)
                    note_mismatch($sformatf("beat %0d source_core %0d, want %0d",
                                            result_beats, result_out.source_core, want.core));
                if (result_out.last !== want.last)
                    note_mismatch($sformatf("beat %0d last %b, want %b",
                                            result_beats, result_out.last, want.last));
            end
        end
    end

    // Hold off the receiver once for a long stretch while the sender keeps
    // offering beats, so the output register fills and the input stalls.
    initial
    begin
        hold_results = 1'b0;
        wait (trace_beats >= HOLD_AT_BEAT);
        @(posedge clk);
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
    end

    // Watchdog: any beat or register access restarts the count.
    always @(posedge clk)
    begin
        if ((trace_in.valid && trace_in.ready) || (result_out.valid && result_out.ready)
            || (psel && penable))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= STALL_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Register access: setup cycle, then access cycle; pready is always high
    // ---------------------------------------------------------------
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // Only core_id exists; bits above its width are dropped
        if (addr == CORE_ID_ADDR)
            core_tag = val[CORE_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_core_id_readback();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CORE_ID_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== PDATA_W'(core_tag))
            note_mismatch($sformatf("core_id reads %h, want %h", prdata, core_tag));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every queued beat is taken and every result has come, then
    // let a flush walk finish before touching registers.
    task automatic wait_quiet();
        while (trace_backlog.size() != 0 || trace_in.valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        errors        = 0;
        trace_beats   = 0;
        result_beats  = 0;
        queued_useful = 0;
        idle_run      = 0;
        trace_taken   = 1'b0;
        settings_run  = 1;
        stack_top     = 0;
        stack_cnt     = 0;
        core_tag      = CORE_ID_RESET;

        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        trace_in.valid     = 1'b0;
        trace_in.cmd       = CMD_TRACE;
        trace_in.payload   = '0;
        result_out.ready   = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, core_id at its reset value
        check_core_id_readback();
        queue_trace(CMD_TRACE, 64'hFFFF_FFFF_FFFF_FFFE);     // return into empty stack
        queue_trace(CMD_TRACE, 64'h0000_0000_0000_0002);
        queue_trace(CMD_EPOCH_END, 64'hFFFF_FFFF_FFFF_FFFF); // epoch end, nothing held
        queue_trace(CMD_TRACE, 64'h0000_0000_0000_0000);     // ignored types
        queue_trace(CMD_TRACE, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_trace(CMD_TRACE, 64'hFFFF_FFFF_FFFF_FFFD);     // call, then matching return
        queue_trace(CMD_TRACE, 64'hFFFF_FFFF_FFFF_FFFE);
        queue_trace(CMD_TRACE, 64'h0000_0000_0000_0001);     // call, then wrong return
        queue_trace(CMD_TRACE, 64'h0000_0000_0000_0006);
        queue_trace(CMD_TRACE, 64'h8000_0000_0000_0001);     // nest of two
        queue_trace(CMD_TRACE, 64'h0123_4567_89AB_CDE5);
        queue_trace(CMD_TRACE, 64'h7FFF_FFFF_FFFF_FFFF);     // ignored mid-nest
        queue_trace(CMD_TRACE, 64'h0123_4567_89AB_CDE6);
        queue_trace(CMD_TRACE, 64'h5555_5555_5555_5555);
        queue_trace(CMD_EPOCH_END, 64'h0000_0000_0000_0000); // spill two held calls
        queue_trace(CMD_TRACE, 64'hAAAA_AAAA_AAAA_AAAA);     // stack empty again
        wait_quiet();

        // Lowest core_id, junk above the field; start with an overflowing nest
        // and a full flush
        reg_write(CORE_ID_ADDR, 32'hFFFF_FFF0);
        check_core_id_readback();
        settings_run++;
        repeat (DEPTH + 3) gen_call();
        gen_epoch();
        random_traffic(ITEMS_PER_SET);
        wait_quiet();

        // Highest core_id; a write to the empty address must not disturb it
        reg_write(CORE_ID_ADDR, 32'h0000_000F);
        reg_write(UNMAPPED_ADDR, 32'h0000_0005);
        check_core_id_readback();
        settings_run++;
        random_traffic(ITEMS_PER_SET);
        wait_quiet();

        reg_write(CORE_ID_ADDR, $urandom);
        check_core_id_readback();
        settings_run++;
        random_traffic(ITEMS_PER_SET);
        wait_quiet();

        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d result beats never arrived", pending_results.size()));

        $display("Covered %0d trace beats and %0d result beats across %0d core_id settings,",
                 trace_beats, result_beats, settings_run);
        $display("including stack overflow spills, full flushes and a long output stall.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
sv/ssc_pkg.sv
sv/ssc_if.sv
sv/ssc_stack_mem.sv
sv/ssc_ctrl.sv
sv/shadow_stack_checker_unit.sv
bench/shadow_stack_checker_unit_tb.sv
